// ===== rtl/lif_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lif_pkg: shared types and constants of the list intersection filter
// Store geometry, opcode codes and the scan token that runs along the cells.
// ---------------------------------------------------------------------------
package lif_pkg;

   localparam int REF_DEPTH  = 1024;
   localparam int VAL_W      = 32;
   localparam int IDX_W      = $clog2(REF_DEPTH);
   localparam int CNT_W      = $clog2(REF_DEPTH + 1);
   localparam int CELL_W     = IDX_W / 2;
   localparam int EPC_W      = IDX_W - CELL_W;
   localparam int NUM_CELLS  = 1 << CELL_W;
   localparam int CELL_DEPTH = 1 << EPC_W;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_PROBE  = 2'd2,
      OP_NOP    = 2'd3
   } lif_op_type;

   // scan token: one local address of every cell, plus the running hit
   typedef struct packed {
      logic             vld;
      logic             last;
      logic [EPC_W-1:0] addr;
      logic             hit;
   } lif_tok_type;

endpackage
`default_nettype wire

// ===== rtl/lif_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lif_cell: one cell of the comparator chain
// Holds one slice of the reference store, matches a passing scan token
// against the candidate and hands the token to the next cell.
// ---------------------------------------------------------------------------
module lif_cell
   import lif_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [CELL_W-1:0] cell_idx,
   input  wire logic              wr_en,
   input  wire logic [CELL_W-1:0] wr_cell,
   input  wire logic [EPC_W-1:0]  wr_addr,
   input  wire logic [VAL_W-1:0]  wr_data,
   input  wire logic [VAL_W-1:0]  cand,
   input  wire logic [CNT_W-1:0]  count,
   input  wire lif_tok_type       tok_in,
   output lif_tok_type            tok_out
);

   logic [VAL_W-1:0] mem [CELL_DEPTH];
   logic [VAL_W-1:0] rd_ff;
   lif_tok_type      tok_ff;
   lif_tok_type      tok_in_q;
   logic [CNT_W-1:0] ent_idx;
   logic             match;

   always_ff @(posedge clock) begin
      if (wr_en && (wr_cell == cell_idx)) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[tok_in.addr];
   end

   always_comb begin
      tok_in_q = tok_in;
      if (reset) begin
         tok_in_q.vld = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in_q;
   end

   // only entries below the fill count take part
   assign ent_idx = CNT_W'({cell_idx, tok_ff.addr});
   assign match   = (ent_idx < count) && (rd_ff == cand);

   always_comb begin
      tok_out     = tok_ff;
      tok_out.hit = tok_ff.hit | match;
   end

endmodule
`default_nettype wire

// ===== rtl/list_intersection_membership_filter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// list_intersection_membership_filter_core: reference list membership filter
// Clear, append and probe requests against a store of reference postings.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Clear, append and
// no-op requests leave busy low and give no result. A probe keeps busy high
// while its scan token enters the chain of NUM_CELLS cells once for each
// of the CELL_DEPTH local addresses, and the last token leaves the final
// cell in the last busy cycle, where the result is registered. The result
// shows on rsp_strobe for one cycle, the first cycle with busy low, and
// cannot be held off; a new request may be given in that same cycle.
// The store needs no clearing pass after reset.
module list_intersection_membership_filter_core
   import lif_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire logic [1:0]       req_opcode,
   input  wire logic [VAL_W-1:0] req_item_value,
   output logic                  rsp_strobe,
   output logic [VAL_W-1:0]      rsp_candidate_value,
   output logic                  rsp_found,
   output logic                  rsp_overflowed
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ISSUE = 3'b010,
      ST_DRAIN = 3'b100
   } lif_state_type;

   lif_state_type    state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [VAL_W-1:0] cand_ff, cand_in;
   logic [EPC_W-1:0] iss_ff, iss_in;
   logic             acc_ff, acc_in;
   logic             strobe_ff, strobe_in;
   logic             found_ff, found_in;

   logic        accept;
   logic        wr_en;
   lif_tok_type chain [NUM_CELLS+1];
   lif_tok_type tok_end;

   assign accept = start && (state_ff == ST_IDLE);
   assign wr_en  = accept && (req_opcode == OP_APPEND) && (count_ff < CNT_W'(REF_DEPTH));

   always_comb begin
      chain[0].vld  = (state_ff == ST_ISSUE);
      chain[0].last = (iss_ff == EPC_W'(CELL_DEPTH - 1));
      chain[0].addr = iss_ff;
      chain[0].hit  = 1'b0;
   end

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      lif_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (CELL_W'(i)),
         .wr_en    (wr_en),
         .wr_cell  (count_ff[IDX_W-1:EPC_W]),
         .wr_addr  (count_ff[EPC_W-1:0]),
         .wr_data  (req_item_value),
         .cand     (cand_ff),
         .count    (count_ff),
         .tok_in   (chain[i]),
         .tok_out  (chain[i+1])
      );
   end

   assign tok_end = chain[NUM_CELLS];

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      cand_in   = cand_ff;
      iss_in    = iss_ff;
      acc_in    = acc_ff;
      strobe_in = 1'b0;
      found_in  = found_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  OP_CLEAR: begin
                     count_in = '0;
                     ovf_in   = 1'b0;
                  end
                  OP_APPEND: begin
                     if (wr_en) begin
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  OP_PROBE: begin
                     cand_in  = req_item_value;
                     iss_in   = '0;
                     acc_in   = 1'b0;
                     state_in = ST_ISSUE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ISSUE: begin
            // advance one local address per cycle into the chain
            iss_in = iss_ff + EPC_W'(1);
            if (iss_ff == EPC_W'(CELL_DEPTH - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // collect hits as tokens leave the last cell
      if (tok_end.vld) begin
         acc_in = acc_ff | tok_end.hit;
         if (tok_end.last) begin
            strobe_in = 1'b1;
            found_in  = acc_ff | tok_end.hit;
            state_in  = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff  <= cand_in;
      iss_ff   <= iss_in;
      acc_ff   <= acc_in;
      found_ff <= found_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_strobe          = strobe_ff;
   assign rsp_candidate_value = cand_ff;
   assign rsp_found           = found_ff;
   assign rsp_overflowed      = ovf_ff;

   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |=> !strobe_ff)
      else $error("two results in a row from one probe");

   a_probe_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_opcode == OP_PROBE)) |=> busy)
      else $error("probe request did not raise busy");

   a_tok_busy: assert property (@(posedge clock) disable iff (reset)
      tok_end.vld |-> busy)
      else $error("scan token left the chain while idle");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(REF_DEPTH))
      else $error("fill count beyond store depth");

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for list_intersection_membership_filter_core
// Drives clear, append, probe and no-op requests: a short directed table,
// then random list sequences, a full-store pass with dropped appends, and
// noise. A store model predicts the answers; directed probes bring fixed ones.
// Each strobed response is checked field by field against the oldest answer.
// ---------------------------------------------------------------------------
module testbench;
   import lif_pkg::*;

   localparam int PROBE_CYCLES    = CELL_DEPTH + NUM_CELLS + 1;
   localparam int RANDOM_REQUESTS = 1080;
   localparam int CYCLE_LIMIT     = 800000;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic             found;
      logic             overflowed;
   } answer_type;

   typedef struct packed {
      lif_op_type       op;
      logic [VAL_W-1:0] value;
      logic             fixed;
      answer_type       answer;
   } stim_row_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   logic [1:0]       req_opcode;
   logic [VAL_W-1:0] req_item_value;
   logic             rsp_strobe;
   logic [VAL_W-1:0] rsp_candidate_value;
   logic             rsp_found;
   logic             rsp_overflowed;

   // local copy of the reference store
   logic [VAL_W-1:0] postings [REF_DEPTH];
   int unsigned      posting_count;
   logic             drop_flag;

   answer_type pending_answers [$];
   int      errors;
   int      cycle_count;
   int      work_sent;
   int      probes_sent;
   int      answers_seen;
   int      hits_seen;
   int      overflow_seen;
   int      burst_left;

   localparam int DIRECTED_ROWS = 19;
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{OP_PROBE,  32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
      '{OP_PROBE,  32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b0}},
      '{OP_NOP,    32'h0000_0005, 1'b0, '0},
      '{OP_APPEND, 32'h0000_0000, 1'b0, '0},
      '{OP_APPEND, 32'hFFFF_FFFF, 1'b0, '0},
      '{OP_APPEND, 32'hA5A5_A5A5, 1'b0, '0},
      '{OP_PROBE,  32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
      '{OP_PROBE,  32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
      '{OP_PROBE,  32'h5A5A_5A5A, 1'b1, '{32'h5A5A_5A5A, 1'b0, 1'b0}},
      '{OP_PROBE,  32'hA5A5_A5A5, 1'b1, '{32'hA5A5_A5A5, 1'b1, 1'b0}},
      '{OP_NOP,    32'hA5A5_A5A5, 1'b0, '0},
      '{OP_PROBE,  32'h0000_0001, 1'b1, '{32'h0000_0001, 1'b0, 1'b0}},
      '{OP_CLEAR,  32'h0000_0000, 1'b0, '0},
      '{OP_PROBE,  32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b0}},
      '{OP_APPEND, 32'h1234_5678, 1'b0, '0},
      '{OP_PROBE,  32'h1234_5678, 1'b1, '{32'h1234_5678, 1'b1, 1'b0}},
      '{OP_PROBE,  32'h1234_5679, 1'b1, '{32'h1234_5679, 1'b0, 1'b0}},
      '{OP_CLEAR,  32'hFFFF_FFFF, 1'b0, '0},
      '{OP_PROBE,  32'h1234_5678, 1'b1, '{32'h1234_5678, 1'b0, 1'b0}}
   };

   list_intersection_membership_filter_core u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_opcode          (req_opcode),
      .req_item_value      (req_item_value),
      .rsp_strobe          (rsp_strobe),
      .rsp_candidate_value (rsp_candidate_value),
      .rsp_found           (rsp_found),
      .rsp_overflowed      (rsp_overflowed)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** list_intersection_membership_filter_core: FAILED **");
         $finish;
      end
   end

   // Update the store model with one request; return 1 when it yields an answer.
   function automatic logic apply_request(input lif_op_type op,
                                          input logic [VAL_W-1:0] value,
                                          output answer_type answer);
      logic hit;
      hit    = 1'b0;
      answer = '0;
      case (op)
         OP_CLEAR: begin
            posting_count = 0;
            drop_flag     = 1'b0;
         end
         OP_APPEND: begin
            if (posting_count < REF_DEPTH) begin
               postings[posting_count] = value;
               posting_count++;
            end else begin
               drop_flag = 1'b1;
            end
         end
         OP_PROBE: begin
            for (int k = 0; k < posting_count; k++)
               if (postings[k] == value) hit = 1'b1;
            answer = '{value, hit, drop_flag};
            return 1'b1;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_strobe) begin
         answers_seen++;
         if (rsp_found) hits_seen++;
         if (rsp_overflowed) overflow_seen++;
         if (pending_answers.size() == 0) begin
            $error("unexpected response, candidate_value %h", rsp_candidate_value);
            errors++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_candidate_value !== want.value) begin
               $error("candidate_value expected %h got %h", want.value, rsp_candidate_value);
               errors++;
            end
            if (rsp_found !== want.found) begin
               $error("found expected %b got %b (candidate %h)",
                      want.found, rsp_found, want.value);
               errors++;
            end
            if (rsp_overflowed !== want.overflowed) begin
               $error("overflowed expected %b got %b (candidate %h)",
                      want.overflowed, rsp_overflowed, want.value);
               errors++;
            end
         end
      end
   end

   // Hold the request until taken; start stays high on return.
   task automatic issue(input lif_op_type op, input logic [VAL_W-1:0] value,
                        input logic fixed, input answer_type fixed_answer);
      answer_type answer;
      logic       taken;
      taken          = 1'b0;
      start          = 1'b1;
      req_opcode     = op;
      req_item_value = value;
      while (!taken) begin
         @(posedge clock);
         taken = !busy;
      end
      if (apply_request(op, value, answer))
         pending_answers.insert(pending_answers.size(), fixed ? fixed_answer : answer);
      if (op != OP_NOP) work_sent++;
      if (op == OP_PROBE) probes_sent++;
      @(negedge clock);
   endtask

   task automatic idle(input int cycles);
      start = 1'b0;
      repeat (cycles) begin
         req_opcode     = 2'($urandom);
         req_item_value = $urandom;
         @(negedge clock);
      end
   endtask

   task automatic send(input lif_op_type op, input logic [VAL_W-1:0] value,
                       input logic fixed = 1'b0, input answer_type fixed_answer = '0);
      if (burst_left == 0) begin
         idle(($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(0, 6));
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      issue(op, value, fixed, fixed_answer);
   endtask

   // Hold the sender until every outstanding answer has come back.
   task automatic drain();
      start = 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
   endtask

   task automatic probe_random();
      logic [VAL_W-1:0] value;
      int               pick;
      pick  = $urandom_range(0, 99);
      value = $urandom;
      if (posting_count > 0 && pick < 45)
         value = postings[$urandom_range(0, posting_count - 1)];
      else if (posting_count > 0 && pick < 60)
         value = postings[$urandom_range(0, posting_count - 1)] ^ (32'h1 << $urandom_range(0, 31));
      else if (pick < 70)
         value = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      send(OP_PROBE, value);
   endtask

   // clear, build a list, then probe it with hits, near misses and misses, with appends and no-ops mixed in
   task automatic list_sequence();
      int appends;
      int probes;
      send(OP_CLEAR, $urandom);
      appends = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 24);
      repeat (appends) begin
         if (posting_count > 0 && $urandom_range(0, 7) == 0)
            send(OP_APPEND, postings[$urandom_range(0, posting_count - 1)]);
         else
            send(OP_APPEND, $urandom);
      end
      probes = $urandom_range(4, 30);
      repeat (probes) begin
         case ($urandom_range(0, 9))
            0:       send(OP_APPEND, $urandom);
            1:       send(OP_NOP, $urandom);
            default: probe_random();
         endcase
      end
   endtask

   task automatic noise_sequence();
      repeat ($urandom_range(3, 12)) send(lif_op_type'($urandom_range(0, 3)), $urandom);
   endtask

   // fill the store to the brim, drop a few appends, then clear the flag again
   task automatic full_store_sequence();
      send(OP_CLEAR, $urandom);
      repeat (REF_DEPTH + $urandom_range(1, 6)) begin
         if ($urandom_range(0, 127) == 0) probe_random();
         send(OP_APPEND, $urandom);
      end
      send(OP_PROBE, postings[REF_DEPTH - 1]);
      send(OP_PROBE, postings[0]);
      repeat (8) probe_random();
      send(OP_CLEAR, $urandom);
      send(OP_PROBE, postings[0]);
      send(OP_APPEND, $urandom);
      send(OP_PROBE, postings[0]);
   endtask

   initial begin
      int base;
      logic full_done;
      errors         = 0;
      cycle_count    = 0;
      work_sent      = 0;
      probes_sent    = 0;
      answers_seen   = 0;
      hits_seen      = 0;
      overflow_seen  = 0;
      burst_left     = 0;
      posting_count  = 0;
      drop_flag      = 1'b0;
      full_done      = 1'b0;
      reset          = 1'b1;
      start          = 1'b0;
      req_opcode     = OP_NOP;
      req_item_value = '0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send(directed_rows[i].op, directed_rows[i].value,
              directed_rows[i].fixed, directed_rows[i].answer);
         if (i == 9) drain();
      end
      drain();

      base = work_sent;
      while (work_sent - base < RANDOM_REQUESTS) begin
         if (!full_done && work_sent - base >= 60) begin
            full_store_sequence();
            full_done = 1'b1;
         end
         case ($urandom_range(0, 9))
            7, 8:    noise_sequence();
            9: begin
               drain();
               list_sequence();
            end
            default: list_sequence();
         endcase
      end

      drain();
      repeat (PROBE_CYCLES + 10) @(posedge clock);
      $display("sent %0d requests (%0d probes) in %0d cycles, including a full-store pass",
               work_sent, probes_sent, cycle_count);
      $display("checked %0d answers: %0d found, %0d with the overflow flag set",
               answers_seen, hits_seen, overflow_seen);
      if (errors == 0)
         $display("** list_intersection_membership_filter_core: PASSED **");
      else
         $display("** list_intersection_membership_filter_core: FAILED **");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/lif_pkg.sv
rtl/lif_cell.sv
rtl/list_intersection_membership_filter_core.sv
sim/testbench.sv
